FILE: sv/sld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sld_pkg
// Shared types and constants for the sync/length deframer.
// ----------------------------------------------------------------------------
package sld_pkg;

    localparam int MAX_FRAME_BYTES = 512;
    localparam int MAX_BODY_LEN    = MAX_FRAME_BYTES - 4;

    localparam int BYTE_W = 8;
    localparam int IDX_W  = 9;
    localparam int LEN_W  = 9;

    localparam logic [BYTE_W-1:0] SYNC_FIRST     = 8'h4C;
    localparam logic [BYTE_W-1:0] SYNC_SECOND    = 8'h4B;
    localparam logic [BYTE_W-1:0] TYPE_PLAIN     = 8'h01;
    localparam logic [BYTE_W-1:0] TYPE_ENCRYPTED = 8'h11;

    typedef enum logic [1:0] {
        ST_PLAIN     = 2'd0,
        ST_ENCRYPTED = 2'd1,
        ST_SHORT     = 2'd2,
        ST_BAD_TYPE  = 2'd3
    } t_status;

    typedef struct packed {
        logic                valid;
        logic [BYTE_W-1:0]   frame_byte;
        logic [IDX_W-1:0]    byte_index;
        logic [LEN_W-1:0]    body_length;
        logic                last_byte;
        t_status             frame_status;
    } t_result;

endpackage

FILE: sv/sld_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sld_parser
// Marker hunt, length check and body sequencing; one byte per step.
// ----------------------------------------------------------------------------
module sld_parser
    import sld_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    output t_result           o_result
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_BODY
    } t_phase;

    t_phase            r_phase,    n_phase;
    logic              r_enable,   n_enable;
    logic              r_prev_l,   n_prev_l;
    logic [BYTE_W-1:0] r_len_hi,   n_len_hi;
    logic [LEN_W-1:0]  r_decl,     n_decl;
    logic [IDX_W-1:0]  r_count,    n_count;
    logic [BYTE_W-1:0] r_type,     n_type;

    logic [2*BYTE_W-1:0] len16;
    logic                len_bad;
    logic                last;
    logic [BYTE_W-1:0]   type_eff;
    t_status             status;

    assign len16    = {r_len_hi, i_byte};
    assign len_bad  = (len16 == '0) || (len16 > (2*BYTE_W)'(MAX_BODY_LEN));
    assign last     = ({1'b0, r_count} + (IDX_W+1)'(1)) >= {1'b0, r_decl};
    assign type_eff = (r_count == '0) ? i_byte : r_type;

    always_comb begin
        if (r_decl < LEN_W'(2)) begin
            status = ST_SHORT;
        end else if (type_eff == TYPE_PLAIN) begin
            status = ST_PLAIN;
        end else if (type_eff == TYPE_ENCRYPTED) begin
            status = ST_ENCRYPTED;
        end else begin
            status = ST_BAD_TYPE;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_enable = r_enable;
        n_prev_l = r_prev_l;
        n_len_hi = r_len_hi;
        n_decl   = r_decl;
        n_count  = r_count;
        n_type   = r_type;

        o_result              = '0;
        o_result.frame_byte   = i_byte;
        o_result.byte_index   = r_count;
        o_result.body_length  = r_decl;
        o_result.last_byte    = last;
        o_result.frame_status = last ? status : ST_PLAIN;

        if (i_cfg_we || (i_step && !r_enable)) begin
            if (i_cfg_we) begin
                n_enable = i_cfg_wdata;
            end
            n_phase  = PH_HUNT;
            n_prev_l = 1'b0;
            n_len_hi = '0;
            n_decl   = '0;
            n_count  = '0;
            n_type   = '0;
        end else if (i_step) begin
            case (r_phase)
                PH_HUNT: begin
                    if (r_prev_l && i_byte == SYNC_SECOND) begin
                        n_prev_l = 1'b0;
                        n_phase  = PH_LEN_HI;
                    end else begin
                        n_prev_l = (i_byte == SYNC_FIRST);
                    end
                end
                PH_LEN_HI: begin
                    n_len_hi = i_byte;
                    n_phase  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    if (len_bad) begin
                        // rescan over the two length bytes
                        if (r_len_hi == SYNC_FIRST && i_byte == SYNC_SECOND) begin
                            n_prev_l = 1'b0;
                            n_phase  = PH_LEN_HI;
                        end else begin
                            n_prev_l = (i_byte == SYNC_FIRST);
                            n_phase  = PH_HUNT;
                        end
                    end else begin
                        n_decl  = len16[LEN_W-1:0];
                        n_count = '0;
                        n_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    o_result.valid = 1'b1;
                    if (r_count == '0) begin
                        n_type = i_byte;
                    end
                    if (last) begin
                        n_phase  = PH_HUNT;
                        n_prev_l = 1'b0;
                        n_count  = '0;
                    end else begin
                        n_count = r_count + IDX_W'(1);
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_enable <= 1'b1;
            r_prev_l <= 1'b0;
            r_len_hi <= '0;
            r_decl   <= '0;
            r_count  <= '0;
            r_type   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_enable <= n_enable;
            r_prev_l <= n_prev_l;
            r_len_hi <= n_len_hi;
            r_decl   <= n_decl;
            r_count  <= n_count;
            r_type   <= n_type;
        end
    end

    a_body_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_decl != '0 && r_count < r_decl))
        else $error("body count outside declared length");

    a_body_length_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_decl <= LEN_W'(MAX_BODY_LEN)))
        else $error("accepted body length above limit");

    a_disabled_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !r_enable && !i_cfg_we) |=> (r_phase == PH_HUNT && !r_prev_l))
        else $error("parser not reset while disabled");

endmodule

FILE: sv/sync_length_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_deframer
// Extracts 'L','K' marked, length-prefixed frames from a mixed byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one received byte per transaction on i_s_axis_tdata.
//   Master stream: one transaction per frame body byte, carrying the byte,
//   its index and the declared body length; tlast marks the final body byte,
//   and tuser carries the frame status on that byte (zero on other bytes).
//   Marker, length bytes, log text and rejected lengths produce nothing.
//   Config: i_cfg_we writes the enable bit; any write drops a partial frame.
//   Write it only while no byte is in flight.
// Flow:
//   One byte per clock sustained while the master side accepts. An
//   accepted byte is held in the input register; its result is registered
//   in the output register. The rate is set by the single parser step.
// Reset: enable = 1, parser hunting for a marker, both stages empty.
// Stall: while the master side is stalled the output register holds its
//   transaction and the input register still takes one more byte, then
//   o_s_axis_tready drops until the output drains.
// ----------------------------------------------------------------------------
module sync_length_deframer
    import sld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [7:0] frame_byte, [16:8] byte_index,
                                          // [25:17] body_length, [31:26] zero
    output logic        o_m_axis_tlast,   // last_byte
    output logic [1:0]  o_m_axis_tuser,   // [1:0] frame_status
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;

    logic    out_free;
    logic    step;
    t_result res;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign step            = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;

    sld_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_result    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= step && res.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
        end
        if (step && res.valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out.body_length, r_out.byte_index, r_out.frame_byte};
    assign o_m_axis_tlast  = r_out.last_byte;
    assign o_m_axis_tuser  = r_out.frame_status;

    a_last_matches_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.last_byte ==
            (({1'b0, r_out.byte_index} + (IDX_W+1)'(1)) >= {1'b0, r_out.body_length})))
        else $error("tlast disagrees with index and length");

    a_status_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last_byte) |-> (r_out.frame_status == ST_PLAIN))
        else $error("status set on a byte that is not last");

    a_short_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last_byte) |->
            ((r_out.frame_status == ST_SHORT) == (r_out.body_length == LEN_W'(1))))
        else $error("short status and body length disagree");

endmodule
